FILE: hdl/tsr_pkg.sv
// types, stage schedule and per-stage datapath of the segment retrim pipeline
package tsr_pkg;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StOutside = 2'd1,
    StZero    = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] start_z;
    logic [31:0] end_x;
    logic [31:0] end_y;
    logic [31:0] end_z;
    logic [17:0] hit_time;
    logic [30:0] hit_distance;
    logic [17:0] cut_start_time;
    logic [17:0] cut_end_time;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] new_start_x;
    logic [31:0] new_start_y;
    logic [31:0] new_start_z;
    logic [31:0] new_end_x;
    logic [31:0] new_end_y;
    logic [31:0] new_end_z;
    logic [17:0] new_hit_time;
    logic [31:0] new_hit_distance;
    logic [1:0]  status;
  } out_beat_t;

  // one unit of time in the time format
  localparam logic [18:0] TimeOne = 19'd65536;
  localparam logic [40:0] OffsetLim = 41'h100_0000_0000;

  // stage schedule
  localparam int SqStage    = 2;
  localparam int SumStage   = 3;
  localparam int RootFirst  = 4;
  localparam int RootSteps  = 33;
  localparam int LenFirst   = 2;
  localparam int LenSteps   = 47;
  localparam int NtFirst    = 2;
  localparam int NtSteps    = 34;
  localparam int SelStage   = 49;
  localparam int ProdStage  = 50;
  localparam int CombStage  = 51;
  localparam int MProdStage = 52;
  localparam int MSumStage  = 53;
  localparam int MInitStage = 54;
  localparam int MDivFirst  = 55;
  localparam int MDivSteps  = 41;
  localparam int LastStage  = 95;

  typedef struct packed {
    logic [2:0][31:0] s;
    logic [2:0][31:0] e;
    logic [17:0]      t;
    logic [30:0]      hdist;
    logic [17:0]      cs;
    logic [17:0]      ce;
    logic [2:0][31:0] dm;
    logic [2:0]       dneg;
    logic             degen;
    logic [2:0][63:0] sq;
    logic [65:0]      srem;
    logic [32:0]      sres;
    logic             tzero;
    logic             tneg;
    logic [17:0]      lr;
    logic [46:0]      lnum;
    logic [17:0]      lden;
    logic             spanzero;
    logic             ntneg;
    logic [17:0]      nr;
    logic [33:0]      nnum;
    logic [17:0]      nden;
    logic [46:0]      lmag;
    logic             lneg;
    logic [41:0]      ps_lo;
    logic [40:0]      ps_hi;
    logic [41:0]      pe_lo;
    logic [40:0]      pe_hi;
    logic [41:0]      pn_lo;
    logic [40:0]      pn_hi;
    logic [48:0]      adjs;
    logic             adjs_neg;
    logic [48:0]      adje;
    logic             adje_neg;
    logic [48:0]      nlen;
    logic [5:0][56:0] mlo;
    logic [5:0][55:0] mhi;
    logic [5:0][80:0] mn;
    logic [5:0]       msat;
    logic [5:0][32:0] mr;
    logic [5:0][40:0] mnum;
    logic [41:0]      pll;
    logic [41:0]      plh;
    logic [40:0]      phl;
    logic [40:0]      phh;
    logic [58:0]      pa;
    logic [57:0]      pb;
    logic [82:0]      pp;
  } item_t;

  function automatic logic [31:0] sat32(logic signed [42:0] v);
    logic [31:0] r;
    if (v > 43'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -43'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // work of pipeline stage k on the item leaving stage k-1
  function automatic item_t stage_step(int k, item_t x);
    item_t       y;
    logic [32:0] dd;
    logic [32:0] dabs;
    logic [17:0] tabs;
    logic [17:0] csabs;
    logic [18:0] tc;
    logic [18:0] sp;
    logic [18:0] tca;
    logic [18:0] spa;
    logic [18:0] aa;
    logic [18:0] aabs;
    logic [18:0] rr19;
    logic [33:0] rr34;
    logic [65:0] trial;
    logic [64:0] ws;
    logic [64:0] we;
    logic [64:0] wn;
    logic [48:0] adj;
    logic        qb;
    int          b;
    y = x;

    if (k == 1) begin
      for (int i = 0; i < 3; i++) begin
        dd = {x.e[i][31], x.e[i]} - {x.s[i][31], x.s[i]};
        dabs = dd[32] ? (33'd0 - dd) : dd;
        y.dneg[i] = dd[32];
        y.dm[i] = dabs[31:0];
      end
      y.degen = (x.s == x.e);
      tabs = x.t[17] ? (18'd0 - x.t) : x.t;
      y.tzero = (x.t == 18'd0);
      y.tneg = x.t[17];
      y.lden = tabs;
      y.lr = '0;
      y.lnum = {x.hdist, 16'd0};
      tc = {x.t[17], x.t} - {x.cs[17], x.cs};
      sp = {x.ce[17], x.ce} - {x.cs[17], x.cs};
      tca = tc[18] ? (19'd0 - tc) : tc;
      spa = sp[18] ? (19'd0 - sp) : sp;
      y.nnum = {tca[17:0], 16'd0};
      y.nden = spa[17:0];
      y.nr = '0;
      y.ntneg = tc[18] ^ sp[18];
      y.spanzero = (sp == 19'd0);
    end

    if (k == SqStage) begin
      for (int i = 0; i < 3; i++) begin
        y.sq[i] = {32'd0, x.dm[i]} * {32'd0, x.dm[i]};
      end
    end

    if (k == SumStage) begin
      y.srem = {2'b0, x.sq[0]} + {2'b0, x.sq[1]} + {2'b0, x.sq[2]};
      y.sres = '0;
    end

    // square root, one result bit per stage
    if (k >= RootFirst && k < RootFirst + RootSteps) begin
      b = RootFirst + RootSteps - 1 - k;
      trial = ({33'd0, x.sres} << (b + 1)) | (66'd1 << (2 * b));
      if (x.srem >= trial) begin
        y.srem = x.srem - trial;
        y.sres = x.sres | (33'd1 << b);
      end
    end

    // distance over time, one quotient bit per stage
    if (k >= LenFirst && k < LenFirst + LenSteps) begin
      rr19 = {x.lr, x.lnum[46]};
      qb = 1'b0;
      if (rr19 >= {1'b0, x.lden}) begin
        rr19 = rr19 - {1'b0, x.lden};
        qb = 1'b1;
      end
      y.lr = rr19[17:0];
      y.lnum = {x.lnum[45:0], qb};
    end

    // rescaled hit time
    if (k >= NtFirst && k < NtFirst + NtSteps) begin
      rr19 = {x.nr, x.nnum[33]};
      qb = 1'b0;
      if (rr19 >= {1'b0, x.nden}) begin
        rr19 = rr19 - {1'b0, x.nden};
        qb = 1'b1;
      end
      y.nr = rr19[17:0];
      y.nnum = {x.nnum[32:0], qb};
    end

    if (k == SelStage) begin
      if (x.degen) begin
        y.lmag = '0;
        y.lneg = 1'b0;
      end else if (x.tzero) begin
        y.lmag = {14'd0, x.sres};
        y.lneg = 1'b0;
      end else begin
        y.lmag = x.lnum;
        y.lneg = x.tneg;
      end
    end

    if (k == ProdStage) begin
      csabs = x.cs[17] ? (18'd0 - x.cs) : x.cs;
      aa = TimeOne - {x.ce[17], x.ce};
      aabs = aa[18] ? (19'd0 - aa) : aa;
      y.ps_lo = {24'd0, csabs} * {18'd0, x.lmag[23:0]};
      y.ps_hi = {23'd0, csabs} * {18'd0, x.lmag[46:24]};
      y.pe_lo = {24'd0, aabs[17:0]} * {18'd0, x.lmag[23:0]};
      y.pe_hi = {23'd0, aabs[17:0]} * {18'd0, x.lmag[46:24]};
      y.pn_lo = {24'd0, x.nden} * {18'd0, x.lmag[23:0]};
      y.pn_hi = {23'd0, x.nden} * {18'd0, x.lmag[46:24]};
      y.adjs_neg = x.cs[17] ^ x.lneg;
      y.adje_neg = aa[18] ^ x.lneg;
    end

    if (k == CombStage) begin
      ws = ({24'd0, x.ps_hi} << 24) + {23'd0, x.ps_lo};
      we = ({24'd0, x.pe_hi} << 24) + {23'd0, x.pe_lo};
      wn = ({24'd0, x.pn_hi} << 24) + {23'd0, x.pn_lo};
      y.adjs = ws[64:16];
      y.adje = we[64:16];
      y.nlen = wn[64:16];
    end

    if (k == MProdStage) begin
      for (int j = 0; j < 6; j++) begin
        adj = (j < 3) ? x.adjs : x.adje;
        y.mlo[j] = {25'd0, x.dm[j % 3]} * {32'd0, adj[24:0]};
        y.mhi[j] = {24'd0, x.dm[j % 3]} * {32'd0, adj[48:25]};
      end
      y.pll = {17'd0, x.nlen[24:0]} * {25'd0, x.nnum[16:0]};
      y.plh = {17'd0, x.nlen[24:0]} * {25'd0, x.nnum[33:17]};
      y.phl = {17'd0, x.nlen[48:25]} * {24'd0, x.nnum[16:0]};
      y.phh = {17'd0, x.nlen[48:25]} * {24'd0, x.nnum[33:17]};
    end

    if (k == MSumStage) begin
      for (int j = 0; j < 6; j++) begin
        y.mn[j] = ({25'd0, x.mhi[j]} << 25) + {24'd0, x.mlo[j]};
      end
      y.pa = {17'd0, x.pll} + ({17'd0, x.plh} << 17);
      y.pb = {17'd0, x.phl} + ({17'd0, x.phh} << 17);
    end

    if (k == MInitStage) begin
      for (int j = 0; j < 6; j++) begin
        y.msat[j] = (x.mn[j][80:41] >= {7'd0, x.sres});
        y.mr[j] = x.mn[j][73:41];
        y.mnum[j] = x.mn[j][40:0];
      end
      y.pp = {24'd0, x.pa} + ({25'd0, x.pb} << 25);
    end

    // offset along the direction, six dividers in lockstep
    if (k >= MDivFirst && k < MDivFirst + MDivSteps) begin
      for (int j = 0; j < 6; j++) begin
        rr34 = {x.mr[j], x.mnum[j][40]};
        qb = 1'b0;
        if (rr34 >= {1'b0, x.sres}) begin
          rr34 = rr34 - {1'b0, x.sres};
          qb = 1'b1;
        end
        y.mr[j] = rr34[32:0];
        y.mnum[j] = {x.mnum[j][39:0], qb};
      end
    end

    return y;
  endfunction

endpackage

FILE: hdl/tsr_in_if.sv
// segment input channel
interface tsr_in_if;
  logic               valid;
  logic               ready;
  tsr_pkg::in_beat_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/tsr_out_if.sv
// retrimmed segment result channel
interface tsr_out_if;
  logic               valid;
  logic               ready;
  tsr_pkg::out_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/trace_segment_retrim_top.sv
// segment retrim top level: 97-stage pipeline from segment beat to result beat
//
//   channel  dir  beat             content
//   seg_i    in   in_beat_t        segment, hit time and distance, two cut times
//   res_o    out  out_beat_t       new end points, new hit time and distance, status
//
// one beat per cycle sustained while res_o takes every result; results leave from out_q.
// latency is set by the serial dividers: hit distance over hit time (47 stages, with
// the square root alongside in 33), then the offset dividers (41 stages), one bit each.
// all stages advance together whenever the output register is empty or taken,
// so a stall on res_o holds every stage in place. reset clears the valid bits only.
module trace_segment_retrim_top (
  input  logic clk_i,
  input  logic rst_ni,
  tsr_in_if.sink    seg_i,
  tsr_out_if.source res_o
);

  localparam int Last = tsr_pkg::LastStage;

  tsr_pkg::item_t     stage_d [0:Last];
  tsr_pkg::item_t     stage_q [0:Last];
  tsr_pkg::out_beat_t out_d;
  tsr_pkg::out_beat_t out_q;
  logic [Last+1:0]    valid_q;
  logic               adv;

  assign adv = ~valid_q[Last+1] | res_o.ready;
  assign seg_i.ready = adv;
  assign res_o.valid = valid_q[Last+1];
  assign res_o.payload = out_q;

  always_comb begin
    stage_d[0] = '0;
    stage_d[0].s[0] = seg_i.payload.start_x;
    stage_d[0].s[1] = seg_i.payload.start_y;
    stage_d[0].s[2] = seg_i.payload.start_z;
    stage_d[0].e[0] = seg_i.payload.end_x;
    stage_d[0].e[1] = seg_i.payload.end_y;
    stage_d[0].e[2] = seg_i.payload.end_z;
    stage_d[0].t     = seg_i.payload.hit_time;
    stage_d[0].hdist = seg_i.payload.hit_distance;
    stage_d[0].cs    = seg_i.payload.cut_start_time;
    stage_d[0].ce    = seg_i.payload.cut_end_time;
  end

  for (genvar k = 1; k <= Last; k++) begin : g_stage
    assign stage_d[k] = tsr_pkg::stage_step(k, stage_q[k-1]);
  end

  // final stage: apply offsets, saturate, status
  tsr_pkg::item_t     fin;
  logic [40:0]        os_mag [3];
  logic [40:0]        oe_mag [3];
  logic signed [42:0] os_v [3];
  logic signed [42:0] oe_v [3];
  logic [31:0]        ns [3];
  logic [31:0]        ne [3];
  logic               nt_neg;
  logic               nt_big;
  logic [66:0]        nd_mag;
  logic [17:0]        nt_o;
  logic [31:0]        nd_o;
  tsr_pkg::status_e   st;

  always_comb begin
    fin = stage_q[Last];
    for (int i = 0; i < 3; i++) begin
      if (fin.degen) begin
        os_mag[i] = '0;
        oe_mag[i] = '0;
      end else begin
        os_mag[i] = (fin.msat[i] || fin.mnum[i] > tsr_pkg::OffsetLim)
                    ? tsr_pkg::OffsetLim : fin.mnum[i];
        oe_mag[i] = (fin.msat[3+i] || fin.mnum[3+i] > tsr_pkg::OffsetLim)
                    ? tsr_pkg::OffsetLim : fin.mnum[3+i];
      end
      os_v[i] = (fin.dneg[i] ^ fin.adjs_neg) ? -$signed({2'b00, os_mag[i]})
                                             : $signed({2'b00, os_mag[i]});
      oe_v[i] = (fin.dneg[i] ^ fin.adje_neg) ? -$signed({2'b00, oe_mag[i]})
                                             : $signed({2'b00, oe_mag[i]});
      ns[i] = tsr_pkg::sat32($signed({{11{fin.s[i][31]}}, fin.s[i]}) + os_v[i]);
      ne[i] = tsr_pkg::sat32($signed({{11{fin.e[i][31]}}, fin.e[i]}) - oe_v[i]);
    end

    nt_neg = fin.ntneg && (fin.nnum != 34'd0);
    nt_big = !nt_neg && (fin.nnum > 34'd65536);
    if (nt_neg) begin
      nt_o = (fin.nnum > 34'd131072) ? 18'h20000 : 18'(34'd0 - fin.nnum);
    end else begin
      nt_o = (fin.nnum > 34'd131071) ? 18'h1ffff : fin.nnum[17:0];
    end

    nd_mag = fin.pp[82:16];
    if (nt_neg) begin
      nd_o = (nd_mag > 67'd2147483648) ? 32'h8000_0000 : 32'(67'd0 - nd_mag);
    end else begin
      nd_o = (nd_mag > 67'd2147483647) ? 32'h7fff_ffff : nd_mag[31:0];
    end

    if (fin.spanzero) begin
      nt_o = '0;
      nd_o = '0;
      st = tsr_pkg::StZero;
    end else if (nt_neg || nt_big) begin
      st = tsr_pkg::StOutside;
    end else begin
      st = tsr_pkg::StOk;
    end

    out_d.new_start_x      = ns[0];
    out_d.new_start_y      = ns[1];
    out_d.new_start_z      = ns[2];
    out_d.new_end_x        = ne[0];
    out_d.new_end_y        = ne[1];
    out_d.new_end_z        = ne[2];
    out_d.new_hit_time     = nt_o;
    out_d.new_hit_distance = nd_o;
    out_d.status           = st;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stage_q <= stage_d;
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[Last:0], seg_i.valid};
    end
  end

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for the segment retrim pipeline
`timescale 1ns / 100ps

module tb;

  localparam int  GapMax   = 17;
  localparam int  DogLimit = 4000;
  localparam int  Drain    = 150;
  localparam int  NumRand  = 950;
  localparam longint TOne  = 64'sd65536;
  localparam longint OffLim = 64'sd1 <<< 40;

  logic clk_i;
  logic rst_ni;

  tsr_in_if  seg_if ();
  tsr_out_if res_if ();

  trace_segment_retrim_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg_if),
    .res_o  (res_if)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  tsr_pkg::in_beat_t  seg_pending_q[$];
  tsr_pkg::out_beat_t retrim_exp_q[$];
  int        n_errors;
  int        n_segs;
  int        n_results;
  int        n_zero_span;
  int        n_outside;
  int        dog_cnt;
  int        seg_gap;
  int        res_stall;
  bit        seg_burst;
  bit        res_burst;

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] mag64(longint v);
    return (v < 0) ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

  function automatic longint signed_mag(logic [63:0] m, bit neg);
    longint r;
    if (m > 64'h7fff_ffff_ffff_ffff) m = 64'h7fff_ffff_ffff_ffff;
    r = longint'(m);
    return neg ? -r : r;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // (a * b) >> sh toward zero, saturated
  function automatic longint mul_shift(longint a, longint b, int sh);
    logic [127:0] p;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    p = p >> sh;
    return signed_mag((p[127:64] != 0) ? 64'hffff_ffff_ffff_ffff : p[63:0],
                      (a < 0) != (b < 0));
  endfunction

  // (a * b) / d toward zero, saturated
  function automatic longint mul_div(longint a, longint b, logic [63:0] d);
    logic [127:0] p;
    logic [127:0] q;
    logic [63:0]  m;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    if (p[127:64] >= d) begin
      m = 64'hffff_ffff_ffff_ffff;
    end else begin
      q = p / {64'd0, d};
      m = q[63:0];
    end
    return signed_mag(m, (a < 0) != (b < 0));
  endfunction

  function automatic tsr_pkg::out_beat_t retrim_predict(tsr_pkg::in_beat_t b);
    tsr_pkg::out_beat_t r;
    longint       s[3];
    longint       e[3];
    longint       d[3];
    longint       t, cs, ce, len, adj_s, adj_e, span, nt, nd, newlen, os, oe;
    logic [127:0] sum;
    logic [127:0] c;
    logic [63:0]  norm;
    logic [63:0]  q;
    tsr_pkg::status_e st;
    s[0] = longint'($signed(b.start_x));
    s[1] = longint'($signed(b.start_y));
    s[2] = longint'($signed(b.start_z));
    e[0] = longint'($signed(b.end_x));
    e[1] = longint'($signed(b.end_y));
    e[2] = longint'($signed(b.end_z));
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = e[i] - s[i];
      sum = sum + {64'd0, mag64(d[i])} * {64'd0, mag64(d[i])};
    end
    t  = longint'($signed(b.hit_time));
    cs = longint'($signed(b.cut_start_time));
    ce = longint'($signed(b.cut_end_time));
    norm = '0;
    for (int k = 34; k >= 0; k--) begin
      c = {64'd0, norm | (64'd1 << k)};
      if (c * c <= sum) norm = c[63:0];
    end
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
      len = 0;
    end else if (t == 0) begin
      len = longint'(norm);
    end else begin
      q = {17'd0, b.hit_distance, 16'd0} / mag64(t);
      len = signed_mag(q, t < 0);
    end
    adj_s = mul_shift(cs, len, 16);
    adj_e = mul_shift(TOne - ce, len, 16);
    for (int i = 0; i < 3; i++) begin
      os = 0;
      oe = 0;
      if (norm != 0) begin
        os = clampl(mul_div(d[i], adj_s, norm), -OffLim, OffLim);
        oe = clampl(mul_div(d[i], adj_e, norm), -OffLim, OffLim);
      end
      s[i] = clampl(s[i] + os, -64'sd2147483648, 64'sd2147483647);
      e[i] = clampl(e[i] - oe, -64'sd2147483648, 64'sd2147483647);
    end
    r.new_start_x = s[0][31:0];
    r.new_start_y = s[1][31:0];
    r.new_start_z = s[2][31:0];
    r.new_end_x   = e[0][31:0];
    r.new_end_y   = e[1][31:0];
    r.new_end_z   = e[2][31:0];
    nt = 0;
    nd = 0;
    st = tsr_pkg::StOk;
    span = ce - cs;
    if (span == 0) begin
      st = tsr_pkg::StZero;
    end else begin
      nt = ((t - cs) * TOne) / span;
      newlen = mul_shift(len, span, 16);
      if (newlen < 0) newlen = -newlen;
      nd = mul_shift(newlen, nt, 16);
      if (nt < 0 || nt > TOne) st = tsr_pkg::StOutside;
    end
    nt = clampl(nt, -64'sd131072, 64'sd131071);
    nd = clampl(nd, -64'sd2147483648, 64'sd2147483647);
    r.new_hit_time     = nt[17:0];
    r.new_hit_distance = nd[31:0];
    r.status           = st;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 20000)) - 10000);
      2:       return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom)};
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [17:0] rand_time();
    case ($urandom_range(0, 5))
      0:       return 18'($urandom);
      1:       return 18'd0;
      2:       return 18'd65536;
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic tsr_pkg::in_beat_t rand_seg();
    tsr_pkg::in_beat_t b;
    b.start_x = rand_coord();
    b.start_y = rand_coord();
    b.start_z = rand_coord();
    b.end_x   = rand_coord();
    b.end_y   = rand_coord();
    b.end_z   = rand_coord();
    // degenerate segments now and then
    if ($urandom_range(0, 15) == 0) begin
      b.end_x = b.start_x;
      b.end_y = b.start_y;
      b.end_z = b.start_z;
    end
    b.hit_time       = rand_time();
    b.hit_distance   = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 100000));
    b.cut_start_time = rand_time();
    b.cut_end_time   = ($urandom_range(0, 15) == 0) ? b.cut_start_time : rand_time();
    return b;
  endfunction

  function automatic tsr_pkg::in_beat_t mk_seg(logic [31:0] sx, logic [31:0] sy,
                                               logic [31:0] sz, logic [31:0] ex,
                                               logic [31:0] ey, logic [31:0] ez,
                                               logic [17:0] t, logic [30:0] hdist,
                                               logic [17:0] cs, logic [17:0] ce);
    tsr_pkg::in_beat_t b;
    b = '{sx, sy, sz, ex, ey, ez, t, hdist, cs, ce};
    return b;
  endfunction

  function automatic int draw_wait(ref bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, GapMax);
  endfunction

  initial begin
    rst_ni = 1'b0;
    seg_if.valid = 1'b0;
    seg_if.payload = '0;
    res_if.ready = 1'b0;
    // all zero, degenerate segment
    seg_pending_q.push_back(mk_seg(0, 0, 0, 0, 0, 0, 0, 0, 0, 18'd65536));
    // degenerate segment with a hit
    seg_pending_q.push_back(mk_seg(32'd500, -32'sd70, 32'd9, 32'd500, -32'sd70, 32'd9,
                                   18'd32768, 31'd1000, 18'd16384, 18'd49152));
    // zero hit time: length from the norm
    seg_pending_q.push_back(mk_seg(0, 0, 0, 32'd768, 32'd1024, 0, 0, 31'd5,
                                   18'd6553, 18'd58982));
    // negative hit time
    seg_pending_q.push_back(mk_seg(32'd100, 32'd200, 32'd300, -32'sd4000, 32'd50, 32'd7000,
                                   18'h3c000, 31'd123456, 18'd0, 18'd65536));
    // opposite coordinate extremes
    seg_pending_q.push_back(mk_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                   0, 31'h7fff_ffff, 18'h20000, 18'h1ffff));
    seg_pending_q.push_back(mk_seg(32'h7fff_ffff, 32'h8000_0000, 0,
                                   32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                   18'd1, 31'h7fff_ffff, 18'h1ffff, 18'h20000));
    // zero span
    seg_pending_q.push_back(mk_seg(0, 0, 0, 32'd256, 32'd256, 32'd256,
                                   18'd30000, 31'd400, 18'd20000, 18'd20000));
    // hit before and after the new segment
    seg_pending_q.push_back(mk_seg(0, 0, 0, 32'd25600, 0, 0,
                                   18'd6553, 31'd2560, 18'd32768, 18'd65536));
    seg_pending_q.push_back(mk_seg(0, 0, 0, 0, 32'd25600, 0,
                                   18'd60000, 31'd23000, 18'd0, 18'd32768));
    // time extremes, maximal distance
    seg_pending_q.push_back(mk_seg(32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6,
                                   18'h20000, 31'h7fff_ffff, 18'h1ffff, 18'h20000));
    seg_pending_q.push_back(mk_seg(-32'sd1, -32'sd1, -32'sd1, 32'd1, 32'd1, 32'd1,
                                   18'h1ffff, 31'h7fff_ffff, 18'h20000, 18'h1ffff));
    seg_pending_q.push_back(mk_seg(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0,
                                   18'h3ffff, 31'd1, 18'h3ffff, 18'h3fffe));
    for (int i = 0; i < NumRand; i++) seg_pending_q.push_back(rand_seg());

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (seg_pending_q.size() == 0 && !seg_if.valid && retrim_exp_q.size() == 0);
    repeat (Drain) @(posedge clk_i);
    $display("%0d segments sent, %0d results checked (%0d zero span, %0d hit outside)",
             n_segs, n_results, n_zero_span, n_outside);
    if (n_errors == 0 && retrim_exp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_if.valid <= 1'b0;
      seg_if.payload <= '0;
      seg_gap <= 0;
      seg_burst <= 1'b0;
    end else if (!(seg_if.valid && !seg_if.ready)) begin
      if (seg_if.valid) begin
        retrim_exp_q.push_back(retrim_predict(seg_if.payload));
        n_segs <= n_segs + 1;
      end
      if (seg_gap > 0) begin
        seg_if.valid <= 1'b0;
        seg_gap <= seg_gap - 1;
      end else if (seg_pending_q.size() > 0) begin
        seg_if.valid <= 1'b1;
        seg_if.payload <= seg_pending_q.pop_front();
        seg_gap <= draw_wait(seg_burst);
      end else begin
        seg_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic cmp_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, fname, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tsr_pkg::out_beat_t want;
    tsr_pkg::out_beat_t got;
    int                 w;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      res_stall <= 0;
      res_burst <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = res_if.payload;
        n_results <= n_results + 1;
        if (got.status == tsr_pkg::StZero) n_zero_span <= n_zero_span + 1;
        if (got.status == tsr_pkg::StOutside) n_outside <= n_outside + 1;
        if (retrim_exp_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h", $time, got);
          n_errors++;
        end else begin
          want = retrim_exp_q.pop_front();
          cmp_field("new_start_x", want.new_start_x, got.new_start_x);
          cmp_field("new_start_y", want.new_start_y, got.new_start_y);
          cmp_field("new_start_z", want.new_start_z, got.new_start_z);
          cmp_field("new_end_x", want.new_end_x, got.new_end_x);
          cmp_field("new_end_y", want.new_end_y, got.new_end_y);
          cmp_field("new_end_z", want.new_end_z, got.new_end_z);
          cmp_field("new_hit_time", 32'(want.new_hit_time), 32'(got.new_hit_time));
          cmp_field("new_hit_distance", want.new_hit_distance, got.new_hit_distance);
          cmp_field("status", 32'(want.status), 32'(got.status));
        end
        // zero wait keeps ready high for the next beat
        w = draw_wait(res_burst);
        res_stall <= (w > 0) ? w - 1 : 0;
        res_if.ready <= (w == 0);
      end else if (res_stall > 0) begin
        res_if.ready <= 1'b0;
        res_stall <= res_stall - 1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i) begin
    if (!rst_ni || (seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready)) begin
      dog_cnt <= 0;
    end else if (dog_cnt >= DogLimit) begin
      $display("%0t: no beat accepted for %0d cycles", $time, DogLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      dog_cnt <= dog_cnt + 1;
    end
  end

endmodule
